### rtl/core/ogr_pkg.sv
package ogr_pkg;

    // grid geometry and cell format
    localparam int GRID_X     = 512;
    localparam int GRID_Y     = 512;
    localparam int VALUE_BITS = 16;
    localparam int CELLS      = GRID_X * GRID_Y;
    localparam int CELL_AW    = $clog2(CELLS);
    localparam int GX_W       = $clog2(GRID_X);
    localparam int GY_W       = $clog2(GRID_Y);

    // field widths
    localparam int CFG_COORD_W = 9;
    localparam int IN_COORD_W  = 12;
    localparam int DELTA_W     = 16;
    localparam int OUT_VALUE_W = 16;
    localparam int COUNT_W     = 11;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    // walk arithmetic: coordinates, axis lengths and error term
    localparam int COORD_W = 13;
    localparam int LEN_W   = 12;
    localparam int ERR_W   = 15;

    // saturating add
    localparam int SUM_W = ((VALUE_BITS > DELTA_W) ? VALUE_BITS : DELTA_W) + 1;
    localparam logic signed [SUM_W-1:0] SUM_HI =
        {{(SUM_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO =
        {{(SUM_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic signed [VALUE_BITS-1:0] cell_t;
    typedef logic signed [COORD_W-1:0]    coord_t;
    typedef logic [CELL_AW-1:0]           addr_t;

    typedef enum logic [1:0] {
        OP_RAY   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_START_X        = 3'd0,
        REG_START_Y        = 3'd1,
        REG_OCCUPIED_DELTA = 3'd2,
        REG_FREE_DELTA     = 3'd3,
        REG_UNKNOWN_LEVEL  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        WALK_HOLD    = 3'd0,
        WALK_LOAD    = 3'd1,
        WALK_INIT    = 3'd2,
        WALK_MINOR   = 3'd3,
        WALK_ADVANCE = 3'd4
    } walk_cmd_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   done;
    } walk_status_t;

    // cell lies inside the grid
    function automatic logic in_grid(coord_t x, coord_t y);
        return !x[COORD_W-1] && !y[COORD_W-1] && (int'(x) < GRID_X) && (int'(y) < GRID_Y);
    endfunction

    // row-major cell address, valid for in-grid cells
    function automatic addr_t cell_addr(coord_t x, coord_t y);
        logic [GX_W-1:0] xu;
        logic [GY_W-1:0] yu;
        addr_t           a;
        xu = x[GX_W-1:0];
        yu = y[GY_W-1:0];
        a  = CELL_AW'(yu) * CELL_AW'(GRID_X) + CELL_AW'(xu);
        return a;
    endfunction

    // low 16 bits of the sign-extended cell
    function automatic logic signed [OUT_VALUE_W-1:0] cell_out(cell_t c);
        logic signed [SUM_W-1:0] t;
        t = SUM_W'(c);
        return t[OUT_VALUE_W-1:0];
    endfunction

endpackage

### rtl/core/occupancy_grid_ray_update.sv
// Log-odds occupancy grid of 512 x 512 cells held in one on-chip RAM, updated by ray items.
// One item is worked on at a time and s_ready is high only while the block waits for work.
// In a ray item each in-grid cell walked takes one RAM read-modify-write and a walked cell
// that lies outside the grid is only stepped past; the walk covers the major-axis distance
// from the robot cell to the endpoint (up to 2559 cells). A clear item sweeps the RAM one
// cell per cycle. After reset the same sweep fills the grid with zero before the first item
// is taken; configuration writes are taken during it. The result register lets the next
// item start while a result waits for m_ready.
module occupancy_grid_ray_update (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [1:0]                               s_opcode,
    input  logic signed [ogr_pkg::IN_COORD_W-1:0]    s_cell_x,
    input  logic signed [ogr_pkg::IN_COORD_W-1:0]    s_cell_y,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [ogr_pkg::OUT_VALUE_W-1:0]   m_cell_value,
    output logic [ogr_pkg::COUNT_W-1:0]              m_cells_changed,
    output logic                                     m_outside_grid,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [ogr_pkg::APB_AW-1:0]               paddr,
    input  logic [ogr_pkg::APB_DW-1:0]               pwdata,
    output logic [ogr_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready
);

    typedef enum logic [8:0] {
        ST_SWEEP     = 9'b000000001,
        ST_IDLE      = 9'b000000010,
        ST_HIT_RD    = 9'b000000100,
        ST_HIT_WR    = 9'b000001000,
        ST_CELL_RD   = 9'b000010000,
        ST_CELL_WR   = 9'b000100000,
        ST_READ_RD   = 9'b001000000,
        ST_READ_DATA = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [ogr_pkg::CFG_COORD_W-1:0]    start_x_reg, start_y_reg;
    logic signed [ogr_pkg::DELTA_W-1:0] occupied_delta_reg, free_delta_reg;
    logic signed [ogr_pkg::DELTA_W-1:0] unknown_level_reg;
    logic                               cfg_wr;
    ogr_pkg::reg_idx_t                  cfg_idx;

    // sequencer state
    ogr_pkg::addr_t sweep_ctr_reg, sweep_ctr_next;
    ogr_pkg::cell_t fill_reg, fill_next;
    logic           reply_reg, reply_next;
    logic           m_valid_reg, m_valid_next;

    // item and result working registers
    logic signed [ogr_pkg::IN_COORD_W-1:0]  ex_reg, ex_next, ey_reg, ey_next;
    ogr_pkg::addr_t                         addr_reg, addr_next;
    logic                                   hit_in_reg, hit_in_next;
    logic signed [ogr_pkg::OUT_VALUE_W-1:0] value_reg, value_next;
    logic [ogr_pkg::COUNT_W-1:0]            count_reg, count_next;
    logic                                   outside_reg, outside_next;
    logic signed [ogr_pkg::OUT_VALUE_W-1:0] m_cell_value_reg;
    logic [ogr_pkg::COUNT_W-1:0]            m_cells_changed_reg;
    logic                                   m_outside_grid_reg;

    // datapath
    logic                               accept, out_load, use_end;
    ogr_pkg::opcode_t                   op;
    ogr_pkg::walk_cmd_t                 walk_cmd;
    ogr_pkg::walk_status_t              walk_status;
    ogr_pkg::coord_t                    pt_x, pt_y;
    logic                               pt_in;
    ogr_pkg::addr_t                     pt_addr;
    ogr_pkg::cell_t                     alu_base, alu_sum, ram_rdata, ram_wdata;
    logic signed [ogr_pkg::DELTA_W-1:0] alu_delta;
    logic                               ram_re, ram_we;
    ogr_pkg::addr_t                     ram_waddr;

    // apb register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = ogr_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg        <= ogr_pkg::CFG_COORD_W'(256);
            start_y_reg        <= ogr_pkg::CFG_COORD_W'(256);
            occupied_delta_reg <= ogr_pkg::DELTA_W'(217);
            free_delta_reg     <= ogr_pkg::DELTA_W'(-104);
            unknown_level_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ogr_pkg::REG_START_X:        start_x_reg <= pwdata[ogr_pkg::CFG_COORD_W-1:0];
                ogr_pkg::REG_START_Y:        start_y_reg <= pwdata[ogr_pkg::CFG_COORD_W-1:0];
                ogr_pkg::REG_OCCUPIED_DELTA: occupied_delta_reg <= pwdata[ogr_pkg::DELTA_W-1:0];
                ogr_pkg::REG_FREE_DELTA:     free_delta_reg <= pwdata[ogr_pkg::DELTA_W-1:0];
                ogr_pkg::REG_UNKNOWN_LEVEL:  unknown_level_reg <= pwdata[ogr_pkg::DELTA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ogr_pkg::REG_START_X:        prdata = ogr_pkg::APB_DW'(start_x_reg);
            ogr_pkg::REG_START_Y:        prdata = ogr_pkg::APB_DW'(start_y_reg);
            ogr_pkg::REG_OCCUPIED_DELTA: prdata = ogr_pkg::APB_DW'(occupied_delta_reg);
            ogr_pkg::REG_FREE_DELTA:     prdata = ogr_pkg::APB_DW'(free_delta_reg);
            ogr_pkg::REG_UNKNOWN_LEVEL:  prdata = ogr_pkg::APB_DW'(unknown_level_reg);
            default:                     prdata = '0;
        endcase
    end

    // handshakes
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign op       = ogr_pkg::opcode_t'(s_opcode);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // cell under work: endpoint for hit and read, walker otherwise
    assign use_end = (state_reg == ST_HIT_RD) || (state_reg == ST_READ_RD);
    assign pt_x    = use_end ? ogr_pkg::coord_t'(ex_reg) : walk_status.x;
    assign pt_y    = use_end ? ogr_pkg::coord_t'(ey_reg) : walk_status.y;
    assign pt_in   = ogr_pkg::in_grid(pt_x, pt_y);
    assign pt_addr = ogr_pkg::cell_addr(pt_x, pt_y);

    // shared saturating adder: fill clamp on clear, cell update otherwise
    assign alu_base  = (state_reg == ST_IDLE) ? '0 : ram_rdata;
    assign alu_delta = (state_reg == ST_IDLE)   ? unknown_level_reg :
                       (state_reg == ST_HIT_WR) ? occupied_delta_reg : free_delta_reg;

    ogr_cell_alu u_alu (
        .base  (alu_base),
        .delta (alu_delta),
        .sum   (alu_sum)
    );

    ogr_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (walk_cmd),
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .end_x   (s_cell_x),
        .end_y   (s_cell_y),
        .status  (walk_status)
    );

    assign ram_waddr = (state_reg == ST_SWEEP) ? sweep_ctr_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_SWEEP) ? fill_reg : alu_sum;

    ogr_ram #(
        .WIDTH (ogr_pkg::VALUE_BITS),
        .DEPTH (ogr_pkg::CELLS)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (pt_addr),
        .rd_data (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        sweep_ctr_next = sweep_ctr_reg;
        fill_next      = fill_reg;
        reply_next     = reply_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        addr_next      = addr_reg;
        hit_in_next    = hit_in_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        outside_next   = outside_reg;
        walk_cmd       = ogr_pkg::WALK_HOLD;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        unique case (state_reg)
            ST_SWEEP: begin
                ram_we         = 1'b1;
                sweep_ctr_next = sweep_ctr_reg + 1'b1;
                if (sweep_ctr_reg == ogr_pkg::addr_t'(ogr_pkg::CELLS - 1)) begin
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    ex_next      = s_cell_x;
                    ey_next      = s_cell_y;
                    value_next   = '0;
                    count_next   = '0;
                    outside_next = 1'b0;
                    walk_cmd     = ogr_pkg::WALK_LOAD;
                    unique case (op)
                        ogr_pkg::OP_RAY:   state_next = ST_HIT_RD;
                        ogr_pkg::OP_READ:  state_next = ST_READ_RD;
                        ogr_pkg::OP_CLEAR: begin
                            fill_next      = alu_sum;
                            sweep_ctr_next = '0;
                            reply_next     = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_HIT_RD: begin
                ram_re       = pt_in;
                addr_next    = pt_addr;
                hit_in_next  = pt_in;
                outside_next = !pt_in;
                walk_cmd     = ogr_pkg::WALK_INIT;
                state_next   = ST_HIT_WR;
            end
            ST_HIT_WR: begin
                ram_we     = hit_in_reg;
                count_next = ogr_pkg::COUNT_W'(hit_in_reg);
                walk_cmd   = ogr_pkg::WALK_MINOR;
                state_next = ST_CELL_RD;
            end
            ST_CELL_RD: begin
                if (walk_status.done) begin
                    state_next = ST_DONE;
                end else if (pt_in) begin
                    ram_re     = 1'b1;
                    addr_next  = pt_addr;
                    state_next = ST_CELL_WR;
                end else begin
                    // off-grid cells are walked but not touched
                    walk_cmd = ogr_pkg::WALK_ADVANCE;
                end
            end
            ST_CELL_WR: begin
                ram_we   = 1'b1;
                walk_cmd = ogr_pkg::WALK_ADVANCE;
                if (count_reg != ogr_pkg::COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_CELL_RD;
            end
            ST_READ_RD: begin
                ram_re       = pt_in;
                hit_in_next  = pt_in;
                outside_next = !pt_in;
                state_next   = ST_READ_DATA;
            end
            ST_READ_DATA: begin
                value_next = hit_in_reg ? ogr_pkg::cell_out(ram_rdata) : '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    reply_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    assign m_valid_next = out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_ctr_reg <= '0;
            fill_reg      <= '0;
            reply_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_ctr_reg <= sweep_ctr_next;
            fill_reg      <= fill_next;
            reply_reg     <= reply_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        addr_reg    <= addr_next;
        hit_in_reg  <= hit_in_next;
        value_reg   <= value_next;
        count_reg   <= count_next;
        outside_reg <= outside_next;
        if (out_load) begin
            m_cell_value_reg    <= value_reg;
            m_cells_changed_reg <= count_reg;
            m_outside_grid_reg  <= outside_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_value    = m_cell_value_reg;
    assign m_cells_changed = m_cells_changed_reg;
    assign m_outside_grid  = m_outside_grid_reg;

endmodule

### rtl/core/ogr_ram.sv
module ogr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ogr_cell_alu.sv
module ogr_cell_alu (
    input  ogr_pkg::cell_t                        base,
    input  logic signed [ogr_pkg::DELTA_W-1:0]    delta,
    output ogr_pkg::cell_t                        sum
);

    logic signed [ogr_pkg::SUM_W-1:0] wide;

    // exact add with one guard bit
    assign wide = ogr_pkg::SUM_W'(base) + ogr_pkg::SUM_W'(delta);

    // clamp to the cell range
    always_comb begin
        priority if (wide > ogr_pkg::SUM_HI) begin
            sum = ogr_pkg::SUM_HI[ogr_pkg::VALUE_BITS-1:0];
        end else if (wide < ogr_pkg::SUM_LO) begin
            sum = ogr_pkg::SUM_LO[ogr_pkg::VALUE_BITS-1:0];
        end else begin
            sum = wide[ogr_pkg::VALUE_BITS-1:0];
        end
    end

endmodule

### rtl/core/ogr_walker.sv
module ogr_walker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  ogr_pkg::walk_cmd_t                      cmd,
    input  logic [ogr_pkg::CFG_COORD_W-1:0]         start_x,
    input  logic [ogr_pkg::CFG_COORD_W-1:0]         start_y,
    input  logic signed [ogr_pkg::IN_COORD_W-1:0]   end_x,
    input  logic signed [ogr_pkg::IN_COORD_W-1:0]   end_y,
    output ogr_pkg::walk_status_t                   status
);

    localparam ogr_pkg::coord_t STEP_UP   = ogr_pkg::coord_t'(1);
    localparam ogr_pkg::coord_t STEP_DOWN = '1;

    ogr_pkg::coord_t                  x_reg, x_next;
    ogr_pkg::coord_t                  y_reg, y_next;
    logic [ogr_pkg::LEN_W-1:0]        dx_reg, dx_next;
    logic [ogr_pkg::LEN_W-1:0]        dy_reg, dy_next;
    logic                             x_up_reg, x_up_next;
    logic                             y_up_reg, y_up_next;
    logic                             x_major_reg, x_major_next;
    logic signed [ogr_pkg::ERR_W-1:0] err_reg, err_next;
    logic signed [ogr_pkg::ERR_W-1:0] inc_lo_reg, inc_lo_next;
    logic signed [ogr_pkg::ERR_W-1:0] inc_hi_reg, inc_hi_next;
    logic [ogr_pkg::LEN_W-1:0]        left_reg, left_next;

    ogr_pkg::coord_t                  sx, sy, ex, ey, diff_x, diff_y;
    logic [ogr_pkg::LEN_W-1:0]        adx, ady, major, minor;
    logic                             up_x, up_y, x_major_c;
    logic signed [ogr_pkg::ERR_W-1:0] two_minor, two_major, major_s;
    logic signed [ogr_pkg::ERR_W-1:0] err_init, inc_hi_init, err_stepped;
    logic                             err_neg;
    ogr_pkg::coord_t                  x_moved, y_moved;

    // axis lengths and directions from the robot cell
    always_comb begin
        sx     = ogr_pkg::coord_t'({1'b0, start_x});
        sy     = ogr_pkg::coord_t'({1'b0, start_y});
        ex     = ogr_pkg::coord_t'(end_x);
        ey     = ogr_pkg::coord_t'(end_y);
        diff_x = ex - sx;
        diff_y = ey - sy;
        adx    = diff_x[ogr_pkg::COORD_W-1] ? ogr_pkg::LEN_W'(-diff_x)
                                            : ogr_pkg::LEN_W'(diff_x);
        ady    = diff_y[ogr_pkg::COORD_W-1] ? ogr_pkg::LEN_W'(-diff_y)
                                            : ogr_pkg::LEN_W'(diff_y);
        up_x   = !diff_x[ogr_pkg::COORD_W-1] && (diff_x != '0);
        up_y   = !diff_y[ogr_pkg::COORD_W-1] && (diff_y != '0);
    end

    // major axis pick and initial error term, ties go to y
    always_comb begin
        x_major_c   = dx_reg > dy_reg;
        major       = x_major_c ? dx_reg : dy_reg;
        minor       = x_major_c ? dy_reg : dx_reg;
        two_minor   = ogr_pkg::ERR_W'({minor, 1'b0});
        two_major   = ogr_pkg::ERR_W'({major, 1'b0});
        major_s     = ogr_pkg::ERR_W'(major);
        err_init    = two_minor - major_s;
        inc_hi_init = two_minor - two_major;
    end

    // one error update and coordinate moves
    always_comb begin
        err_neg     = err_reg[ogr_pkg::ERR_W-1];
        err_stepped = err_reg + (err_neg ? inc_lo_reg : inc_hi_reg);
        x_moved     = x_reg + (x_up_reg ? STEP_UP : STEP_DOWN);
        y_moved     = y_reg + (y_up_reg ? STEP_UP : STEP_DOWN);
    end

    // command decode
    always_comb begin
        x_next       = x_reg;
        y_next       = y_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        x_up_next    = x_up_reg;
        y_up_next    = y_up_reg;
        x_major_next = x_major_reg;
        err_next     = err_reg;
        inc_lo_next  = inc_lo_reg;
        inc_hi_next  = inc_hi_reg;
        left_next    = left_reg;
        unique case (cmd)
            ogr_pkg::WALK_LOAD: begin
                x_next    = sx;
                y_next    = sy;
                dx_next   = adx;
                dy_next   = ady;
                x_up_next = up_x;
                y_up_next = up_y;
                left_next = '0;
            end
            ogr_pkg::WALK_INIT: begin
                x_major_next = x_major_c;
                err_next     = err_init;
                inc_lo_next  = two_minor;
                inc_hi_next  = inc_hi_init;
                left_next    = major;
            end
            ogr_pkg::WALK_MINOR: begin
                err_next = err_stepped;
                if (!err_neg) begin
                    if (x_major_reg) begin
                        y_next = y_moved;
                    end else begin
                        x_next = x_moved;
                    end
                end
            end
            ogr_pkg::WALK_ADVANCE: begin
                // major move for this step, minor decision for the next
                err_next  = err_stepped;
                left_next = left_reg - 1'b1;
                if (x_major_reg) begin
                    x_next = x_moved;
                    if (!err_neg) begin
                        y_next = y_moved;
                    end
                end else begin
                    y_next = y_moved;
                    if (!err_neg) begin
                        x_next = x_moved;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

    // walk datapath
    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        x_up_reg    <= x_up_next;
        y_up_reg    <= y_up_next;
        x_major_reg <= x_major_next;
        err_reg     <= err_next;
        inc_lo_reg  <= inc_lo_next;
        inc_hi_reg  <= inc_hi_next;
    end

    assign status.x    = x_reg;
    assign status.y    = y_reg;
    assign status.done = (left_reg == '0);

endmodule
